### rtl/core/assert_macros.svh
// assertion macros shared by the motor pot controller modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property on aclk, off while in reset
`define MPPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication
`define MPPC_ASSERT_IMP(label, ante, cons, msg) \
    `MPPC_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define MPPC_ASSERT_NEXT(label, ante, cons, msg) \
    `MPPC_ASSERT(label, (ante) |=> (cons), msg)

`endif

### rtl/core/mppc_pkg.sv
// package with widths, codes and control types of the motor pot controller
package mppc_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int TIMER_W    = 24;
    localparam int EL_W       = 16;
    localparam int PCT_W      = 15;
    localparam int DRIVE_W    = 11;
    localparam int MAG_W      = 10;
    localparam int NOISE_W    = 12;
    localparam int EFS_W      = 12;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;

    localparam int PCT_SCALE = 25600;
    localparam logic [PCT_W-1:0] FULL_PCT = PCT_W'(PCT_SCALE);

    // input word field offsets
    localparam int V_LSB  = 0;
    localparam int EL_LSB = V_LSB + SAMPLE_W;
    localparam int TG_LSB = EL_LSB + EL_W;

    // shared divider sizes
    localparam int DIV_NUM_W = 40;
    localparam int DIV_DEN_W = 27;
    localparam int DIV_Q_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    localparam logic signed [DRIVE_W-1:0] DRIVE_FULL     = DRIVE_W'(1000);
    localparam logic signed [DRIVE_W-1:0] DRIVE_FULL_NEG = -DRIVE_W'(1000);

    localparam logic [NOISE_W-1:0]  RST_NOISE = NOISE_W'(8);
    localparam logic [MAG_W-1:0]    RST_DMAX  = MAG_W'(1000);
    localparam logic [MAG_W-1:0]    RST_DMIN  = MAG_W'(200);
    localparam logic [EFS_W-1:0]    RST_EFS   = EFS_W'(400);
    localparam logic [TIMER_W-1:0]  RST_RAMP  = '0;
    localparam logic [TIMER_W-1:0]  RST_HOLD  = TIMER_W'(1000);

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_TARGET = 2'd1,
        OP_CALIB  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_UNCAL  = 2'd0,
        PH_TO_MAX = 2'd1,
        PH_TO_MIN = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INIT = 2'd0,
        ST_BUSY = 2'd1,
        ST_IDLE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOISE = 3'd0,
        CFG_DMAX  = 3'd1,
        CFG_DMIN  = 3'd2,
        CFG_EFS   = 3'd3,
        CFG_RAMP  = 3'd4,
        CFG_HOLD  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic ramp_eval;
        logic div_start;
        logic div_sel_mag;
        logic ramp_apply;
        logic err_mul;
        logic err_calc;
        logic dead_eval;
        logic mag_mul;
        logic mag_apply;
        logic emit;
        logic emit_second;
    } cmd_t;

    typedef struct packed {
        logic ctrl_tick;
        logic need_rdiv;
        logic settled;
        logic div_done;
        logic out_free;
        logic two_results;
    } sts_t;

endpackage

### rtl/core/mppc_div.sv
// shared restoring divider, one quotient bit per cycle
`include "assert_macros.svh"
module mppc_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [mppc_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [mppc_pkg::DIV_DEN_W-1:0] divisor,
    output logic                           busy,
    output logic                           done,
    output logic [mppc_pkg::DIV_Q_W-1:0]   quotient
);
    import mppc_pkg::*;

    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_Q_W-1:0]   num_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_DEN_W:0] shifted;
    logic [DIV_DEN_W:0] diff;
    logic               ge;

    assign shifted = {rem_reg, num_reg[DIV_Q_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_Q_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // quotient fits in DIV_Q_W bits, so the upper dividend is below the divisor
            rem_reg <= DIV_DEN_W'(dividend[DIV_NUM_W-1:DIV_Q_W]);
            num_reg <= dividend[DIV_Q_W-1:0];
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            num_reg <= {num_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = num_reg;

    `MPPC_ASSERT_IMP(a_div_start_idle, start, !busy_reg, "divider started while busy")
    `MPPC_ASSERT_IMP(a_div_done_after_busy, done_reg, $past(busy_reg) && !busy_reg,
                     "divider done without a finished run")

endmodule

### rtl/core/mppc_datapath.sv
// datapath: config registers, calibration and ramp state, error and drive arithmetic
`include "assert_macros.svh"
module mppc_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mppc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mppc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic [mppc_pkg::S_TDATA_W-1:0]  s_tdata,   // voltage, elapsed, target
    input  logic [mppc_pkg::OP_W-1:0]       s_tuser,   // operation
    input  mppc_pkg::cmd_t                  cmd,
    output mppc_pkg::sts_t                  sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mppc_pkg::M_TDATA_W-1:0]  m_tdata,   // drive, drive_valid, status
    output logic                            m_tlast
);
    import mppc_pkg::*;

    localparam int ERR_W  = 30;
    localparam int AERR_W = 29;
    localparam int HYST_W = 28;
    localparam int SPX_W  = 29;
    localparam int RMUL_W = PCT_W + TIMER_W;
    localparam int P1_W   = MAG_W + DIV_DEN_W;
    localparam int P2_W   = DRIVE_W + DIV_DEN_W;
    localparam int SUM_W  = P2_W + 1;

    function automatic logic [TIMER_W-1:0] sat_add(input logic [TIMER_W-1:0] a,
                                                   input logic [EL_W-1:0] b);
        logic [TIMER_W:0] s;
        s = {1'b0, a} + (TIMER_W+1)'(b);
        return s[TIMER_W] ? {TIMER_W{1'b1}} : s[TIMER_W-1:0];
    endfunction

    function automatic logic [DIV_DEN_W-1:0] scale_pct(input logic [SAMPLE_W-1:0] x);
        return DIV_DEN_W'(x) * DIV_DEN_W'(PCT_SCALE);
    endfunction

    // config
    logic [NOISE_W-1:0] noise_reg, noise_next;
    logic [MAG_W-1:0]   dmax_reg, dmax_next;
    logic [MAG_W-1:0]   dmin_reg, dmin_next;
    logic [EFS_W-1:0]   efs_reg, efs_next;
    logic [TIMER_W-1:0] rt_reg, rt_next;
    logic [TIMER_W-1:0] hold_reg, hold_next;

    // controller state
    phase_t              phase_reg, phase_next;
    status_t             status_reg, status_next;
    logic [SAMPLE_W-1:0] prev_reg, prev_next;
    logic [TIMER_W-1:0]  sc_reg, sc_next;
    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [SAMPLE_W-1:0] hi_reg, hi_next;
    logic [PCT_W-1:0]    spn_reg, spn_next;
    logic [PCT_W-1:0]    spf_reg, spf_next;
    logic [PCT_W-1:0]    sps_reg, sps_next;
    logic [TIMER_W-1:0]  rc_reg, rc_next;
    logic                ra_reg, ra_next;
    logic                two_reg, two_next;

    // latched word and working values
    logic [OP_W-1:0]            op_reg;
    logic [SAMPLE_W-1:0]        v_reg;
    logic [EL_W-1:0]            el_reg;
    logic [PCT_W-1:0]           tg_reg;
    logic [RMUL_W-1:0]          rmul_reg;
    logic signed [SPX_W-1:0]    spx_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic [DIV_DEN_W-1:0]       aerr_reg;
    logic                       neg_reg;
    logic [P1_W-1:0]            p1_reg;
    logic signed [P2_W-1:0]     p2_reg;
    logic signed [DRIVE_W-1:0]  res_drive_reg, res_drive_next;
    logic                       res_valid_reg, res_valid_next;
    logic                       res_last_reg, res_last_next;

    // output stage
    logic                      m_valid_reg;
    logic signed [DRIVE_W-1:0] m_drive_reg;
    logic                      m_dvalid_reg;
    logic [STATUS_W-1:0]       m_status_reg;
    logic                      m_last_reg;

    // combinational helpers
    logic [2*NOISE_W+1:0]      fifth_prod;
    logic [NOISE_W:0]          thr;
    logic [SAMPLE_W-1:0]       dv;
    logic                      stable;
    logic [TIMER_W-1:0]        sc_sat;
    logic [TIMER_W-1:0]        rc_sat;
    logic [PCT_W-1:0]          tg_clamp;
    logic                      ramp_done;
    logic                      ramp_neg;
    logic [PCT_W-1:0]          ramp_ad;
    logic signed [SAMPLE_W:0]  span;
    logic signed [PCT_W:0]     sp_s;
    logic [DIV_DEN_W-1:0]      v_scaled;
    logic [DIV_DEN_W-1:0]      lo_scaled;
    logic [ERR_W-1:0]          err_neg;
    logic [AERR_W-1:0]         aerr;
    logic [HYST_W-1:0]         hyst;
    logic [DIV_DEN_W-1:0]      fs_val;
    logic                      dead;
    logic                      sat;
    logic signed [MAG_W:0]     dd;
    logic signed [DIV_DEN_W:0] aerr_s;
    logic signed [SUM_W-1:0]   num;
    logic [DIV_NUM_W-1:0]      div_dividend;
    logic [DIV_DEN_W-1:0]      div_divisor;
    logic                      div_busy;
    logic                      div_done;
    logic [DIV_Q_W-1:0]        div_q;
    logic signed [DRIVE_W-1:0] mag_q;
    logic signed [DRIVE_W-1:0] mag_sat;
    logic                      out_free;

    // noise/5 via reciprocal, exact for 12-bit values
    assign fifth_prod = (2*NOISE_W+2)'(noise_reg) * (2*NOISE_W+2)'(13108);
    assign thr        = (NOISE_W+1)'(noise_reg) + (NOISE_W+1)'(fifth_prod[2*NOISE_W+1:16]);
    assign dv         = (v_reg >= prev_reg) ? v_reg - prev_reg : prev_reg - v_reg;
    assign stable     = (NOISE_W+1)'(dv) < thr;
    assign sc_sat     = sat_add(sc_reg, el_reg);
    assign rc_sat     = sat_add(rc_reg, el_reg);
    assign tg_clamp   = (tg_reg > FULL_PCT) ? FULL_PCT : tg_reg;

    assign ramp_done = rc_reg >= rt_reg;
    assign ramp_neg  = spf_reg < sps_reg;
    assign ramp_ad   = ramp_neg ? sps_reg - spf_reg : spf_reg - sps_reg;

    assign span      = $signed({1'b0, hi_reg}) - $signed({1'b0, lo_reg});
    assign sp_s      = $signed({1'b0, spn_reg});
    assign v_scaled  = scale_pct(v_reg);
    assign lo_scaled = scale_pct(lo_reg);

    assign err_neg = -err_reg;
    assign aerr    = err_reg[ERR_W-1] ? err_neg[AERR_W-1:0] : err_reg[AERR_W-1:0];
    assign hyst    = HYST_W'({noise_reg, 1'b1}) * HYST_W'(PCT_SCALE);
    assign fs_val  = DIV_DEN_W'(efs_reg) * DIV_DEN_W'(PCT_SCALE);
    assign dead    = aerr <= AERR_W'(hyst);
    assign sat     = aerr >= AERR_W'(fs_val);
    assign mag_sat = $signed({1'b0, dmax_reg});

    assign dd     = $signed({1'b0, dmax_reg}) - $signed({1'b0, dmin_reg});
    assign aerr_s = $signed({1'b0, aerr_reg});
    assign num    = $signed({2'b00, p1_reg}) + SUM_W'(p2_reg);

    assign div_dividend = cmd.div_sel_mag ? DIV_NUM_W'(num[P1_W-1:0])
                                          : DIV_NUM_W'(rmul_reg);
    assign div_divisor  = cmd.div_sel_mag ? fs_val : DIV_DEN_W'(rt_reg);
    assign mag_q        = $signed({1'b0, div_q[MAG_W-1:0]});

    mppc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        noise_next     = noise_reg;
        dmax_next      = dmax_reg;
        dmin_next      = dmin_reg;
        efs_next       = efs_reg;
        rt_next        = rt_reg;
        hold_next      = hold_reg;
        phase_next     = phase_reg;
        status_next    = status_reg;
        prev_next      = prev_reg;
        sc_next        = sc_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        spn_next       = spn_reg;
        spf_next       = spf_reg;
        sps_next       = sps_reg;
        rc_next        = rc_reg;
        ra_next        = ra_reg;
        two_next       = two_reg;
        res_drive_next = res_drive_reg;
        res_valid_next = res_valid_reg;
        res_last_next  = res_last_reg;

        if (cfg_we) begin
            unique case (cfg_index)
                CFG_NOISE: noise_next = cfg_data[NOISE_W-1:0];
                CFG_DMAX:  dmax_next  = cfg_data[MAG_W-1:0];
                CFG_DMIN:  dmin_next  = cfg_data[MAG_W-1:0];
                CFG_EFS:   efs_next   = cfg_data[EFS_W-1:0];
                CFG_RAMP:  rt_next    = cfg_data[TIMER_W-1:0];
                CFG_HOLD:  hold_next  = cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end

        if (cmd.exec) begin
            two_next       = 1'b0;
            res_drive_next = '0;
            res_valid_next = 1'b0;
            res_last_next  = 1'b1;
            case (op_reg)
                OP_TARGET: begin
                    spf_next = tg_clamp;
                    sps_next = spn_reg;
                    if (rt_reg != '0 && tg_clamp != spn_reg) begin
                        ra_next = 1'b1;
                        rc_next = '0;
                    end else begin
                        spn_next = tg_clamp;
                        ra_next  = 1'b0;
                    end
                end
                OP_CALIB: begin
                    phase_next  = PH_TO_MAX;
                    status_next = ST_BUSY;
                    lo_next     = '0;
                    hi_next     = '1;
                    sc_next     = '0;
                    prev_next   = v_reg;
                end
                OP_TICK: begin
                    prev_next = v_reg;
                    case (phase_reg)
                        PH_UNCAL: status_next = ST_INIT;
                        PH_TO_MAX: begin
                            status_next    = ST_BUSY;
                            res_drive_next = DRIVE_FULL;
                            res_valid_next = 1'b1;
                            if (stable) begin
                                sc_next = sc_sat;
                                if (sc_sat >= hold_reg) begin
                                    hi_next    = v_reg;
                                    phase_next = PH_TO_MIN;
                                    sc_next    = '0;
                                end
                            end else begin
                                sc_next = '0;
                            end
                        end
                        PH_TO_MIN: begin
                            status_next    = ST_BUSY;
                            res_drive_next = DRIVE_FULL_NEG;
                            res_valid_next = 1'b1;
                            if (stable) begin
                                sc_next = sc_sat;
                                if (sc_sat >= hold_reg) begin
                                    // endpoint done: full negative, then a stop word
                                    lo_next       = v_reg;
                                    phase_next    = PH_DONE;
                                    res_last_next = 1'b0;
                                    two_next      = 1'b1;
                                end
                            end else begin
                                sc_next = '0;
                            end
                        end
                        default: begin
                            if (ra_reg) begin
                                rc_next = rc_sat;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end

        if (cmd.ramp_eval && ra_reg && ramp_done) begin
            spn_next = spf_reg;
            ra_next  = 1'b0;
            rc_next  = rt_reg;
        end

        if (cmd.ramp_apply) begin
            spn_next = ramp_neg ? sps_reg - div_q[PCT_W-1:0] : sps_reg + div_q[PCT_W-1:0];
        end

        if (cmd.dead_eval) begin
            res_drive_next = '0;
            res_valid_next = 1'b1;
            res_last_next  = 1'b1;
            if (dead) begin
                status_next = ST_IDLE;
            end else begin
                status_next = ST_BUSY;
                if (sat) begin
                    res_drive_next = err_reg[ERR_W-1] ? mag_sat : -mag_sat;
                end
            end
        end

        if (cmd.mag_apply) begin
            res_drive_next = neg_reg ? mag_q : -mag_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_reg  <= RST_NOISE;
            dmax_reg   <= RST_DMAX;
            dmin_reg   <= RST_DMIN;
            efs_reg    <= RST_EFS;
            rt_reg     <= RST_RAMP;
            hold_reg   <= RST_HOLD;
            phase_reg  <= PH_UNCAL;
            status_reg <= ST_INIT;
            prev_reg   <= '0;
            sc_reg     <= '0;
            lo_reg     <= '0;
            hi_reg     <= '1;
            spn_reg    <= '0;
            spf_reg    <= '0;
            sps_reg    <= '0;
            rc_reg     <= '0;
            ra_reg     <= 1'b0;
            two_reg    <= 1'b0;
        end else begin
            noise_reg  <= noise_next;
            dmax_reg   <= dmax_next;
            dmin_reg   <= dmin_next;
            efs_reg    <= efs_next;
            rt_reg     <= rt_next;
            hold_reg   <= hold_next;
            phase_reg  <= phase_next;
            status_reg <= status_next;
            prev_reg   <= prev_next;
            sc_reg     <= sc_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            spn_reg    <= spn_next;
            spf_reg    <= spf_next;
            sps_reg    <= sps_next;
            rc_reg     <= rc_next;
            ra_reg     <= ra_next;
            two_reg    <= two_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_drive_reg <= res_drive_next;
        res_valid_reg <= res_valid_next;
        res_last_reg  <= res_last_next;
        if (cmd.load) begin
            op_reg <= s_tuser;
            v_reg  <= s_tdata[V_LSB +: SAMPLE_W];
            el_reg <= s_tdata[EL_LSB +: EL_W];
            tg_reg <= s_tdata[TG_LSB +: PCT_W];
        end
        if (cmd.ramp_eval) begin
            rmul_reg <= ramp_ad * rc_reg;
        end
        if (cmd.err_mul) begin
            spx_reg <= sp_s * span;
        end
        if (cmd.err_calc) begin
            err_reg <= $signed({3'b000, v_scaled}) - $signed({3'b000, lo_scaled})
                       - ERR_W'(spx_reg);
        end
        if (cmd.dead_eval) begin
            aerr_reg <= aerr[DIV_DEN_W-1:0];
            neg_reg  <= err_reg[ERR_W-1];
        end
        if (cmd.mag_mul) begin
            p1_reg <= dmin_reg * fs_val;
            p2_reg <= dd * aerr_s;
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.emit_second) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_drive_reg  <= res_drive_reg;
            m_dvalid_reg <= res_valid_reg;
            m_status_reg <= status_reg;
            m_last_reg   <= res_last_reg;
        end else if (cmd.emit_second) begin
            m_drive_reg  <= '0;
            m_dvalid_reg <= 1'b1;
            m_status_reg <= status_reg;
            m_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W-DRIVE_W-1-STATUS_W)'(0), m_status_reg, m_dvalid_reg, m_drive_reg};
    assign m_tlast  = m_last_reg;

    assign sts.ctrl_tick   = (op_reg == OP_TICK) && (phase_reg == PH_DONE);
    assign sts.need_rdiv   = ra_reg && !ramp_done;
    assign sts.settled     = dead || sat;
    assign sts.div_done    = div_done;
    assign sts.out_free    = out_free;
    assign sts.two_results = two_reg;

    `MPPC_ASSERT_IMP(a_emit_slot_free, cmd.emit || cmd.emit_second, out_free,
                     "result word written over one not yet taken")
    `MPPC_ASSERT_IMP(a_apply_after_div, cmd.ramp_apply || cmd.mag_apply, div_done && !div_busy,
                     "quotient used before the divider finished")

endmodule

### rtl/core/mppc_ctrl.sv
// sequencer that steps the datapath through one input word at a time
module mppc_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  mppc_pkg::sts_t sts,
    output mppc_pkg::cmd_t cmd
);
    import mppc_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_EXEC     = 13'b0000000000010,
        S_RAMP     = 13'b0000000000100,
        S_RDIV_GO  = 13'b0000000001000,
        S_RDIV     = 13'b0000000010000,
        S_ERR_MUL  = 13'b0000000100000,
        S_ERR_CALC = 13'b0000001000000,
        S_DEAD     = 13'b0000010000000,
        S_MAG_MUL  = 13'b0000100000000,
        S_MAG_GO   = 13'b0001000000000,
        S_MDIV     = 13'b0010000000000,
        S_EMIT     = 13'b0100000000000,
        S_EMIT2    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = sts.ctrl_tick ? S_RAMP : S_EMIT;
            end
            S_RAMP: begin
                cmd.ramp_eval = 1'b1;
                state_next    = sts.need_rdiv ? S_RDIV_GO : S_ERR_MUL;
            end
            S_RDIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = S_RDIV;
            end
            S_RDIV: begin
                if (sts.div_done) begin
                    cmd.ramp_apply = 1'b1;
                    state_next     = S_ERR_MUL;
                end
            end
            S_ERR_MUL: begin
                cmd.err_mul = 1'b1;
                state_next  = S_ERR_CALC;
            end
            S_ERR_CALC: begin
                cmd.err_calc = 1'b1;
                state_next   = S_DEAD;
            end
            S_DEAD: begin
                cmd.dead_eval = 1'b1;
                state_next    = sts.settled ? S_EMIT : S_MAG_MUL;
            end
            S_MAG_MUL: begin
                cmd.mag_mul = 1'b1;
                state_next  = S_MAG_GO;
            end
            S_MAG_GO: begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_mag = 1'b1;
                state_next      = S_MDIV;
            end
            S_MDIV: begin
                if (sts.div_done) begin
                    cmd.mag_apply = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.two_results ? S_EMIT2 : S_IDLE;
                end
            end
            S_EMIT2: begin
                if (sts.out_free) begin
                    cmd.emit_second = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/core/motor_pot_position_controller_core.sv
// top level of the motorized potentiometer position controller
//
// input words arrive on s_tvalid/s_tready: s_tuser is the operation
// (tick, set target, start calibration), s_tdata packs voltage, elapsed
// ticks and target. each word gives one result word on m_tvalid/m_tready,
// or two for the tick that ends calibration (full negative, then stop);
// m_tlast marks the final result of a word.
// one word is handled at a time. target, calibration start and
// calibration ticks go from the accept through the execute state to the
// emit state. a control tick also runs the ramp, error and deadband
// states, plus the ramp setpoint division while ramping and the drive
// magnitude division when the error is between deadband and full scale
// (shared 16-step divider). the next word is taken in the cycle after
// the final result is written to the output register.
// a synchronous low aresetn restores the register defaults and the
// uncalibrated state. a stalled receiver holds the result in the output
// register; the block then waits before writing the next result.
// config writes on cfg_we/cfg_index/cfg_data take effect at the clock edge.
module motor_pot_position_controller_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mppc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mppc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mppc_pkg::S_TDATA_W-1:0]  s_tdata,   // voltage, elapsed, target, zero pad
    input  logic [mppc_pkg::OP_W-1:0]       s_tuser,   // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mppc_pkg::M_TDATA_W-1:0]  m_tdata,   // drive, drive_valid, status, zero pad
    output logic                            m_tlast
);
    import mppc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mppc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mppc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule
